[rtl/lpd_pkg.sv]
// Shared types and constants of the length-prefixed deframer.
`default_nettype none

package lpd_pkg;

  localparam int unsigned LengthBits = 32;  // bits of a header length kept (8..32)
  localparam int unsigned MaxBits    = 32;  // width of the maximum-length register

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ERROR   = 2'd1,
    KIND_END     = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_TRUNC_HEADER  = 3'd1,
    ERR_ZERO_LENGTH   = 3'd2,
    ERR_OVER_MAX      = 3'd3,
    ERR_TRUNC_PAYLOAD = 3'd4
  } err_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } item_t;

endpackage

`default_nettype wire

[rtl/lpd_in_if.sv]
// Byte stream channel: one stream byte or an end-of-stream mark per item.
`default_nettype none

interface lpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

`default_nettype wire

[rtl/lpd_out_if.sv]
// Result channel: payload bytes, frame errors and clean ends.
`default_nettype none

interface lpd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] payload_byte;
  logic       last_in_frame;
  logic [2:0] error_code;

  modport source (output valid, output result_kind, output payload_byte,
                  output last_in_frame, output error_code, input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input last_in_frame, input error_code, output ready);
endinterface

`default_nettype wire

[rtl/length_prefixed_deframer.sv]
// Top level of the length-prefixed deframer.
//
//  channel   dir  handshake     payload
//  in_i      in   valid/ready   in_byte[7:0], end_of_stream
//  out_o     out  valid/ready   result_kind[1:0], payload_byte[7:0],
//                               last_in_frame, error_code[2:0]
//  cfg       in   cfg_we_i      cfg_wdata_i[31:0] = max_frame_length
//
// One item per cycle sustained while out_o is not stalled; an item's result
// is registered after acceptance (input register, then result register).
// Header bytes other than the fourth, and a fourth byte that opens a
// payload, give no result.
// A stalled result holds; the input register still takes one more item.
// Reset clears the frame state and sets max_frame_length to all ones.
`default_nettype none

module length_prefixed_deframer (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  lpd_in_if.sink                           in_i,
  lpd_out_if.source                        out_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [lpd_pkg::MaxBits-1:0] cfg_wdata_i
);

  lpd_pkg::item_t item;
  logic           item_valid;
  logic           take;

  lpd_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .item_o  (item),
    .valid_o (item_valid)
  );

  lpd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_i     (item_valid),
    .item_i      (item),
    .take_o      (take),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

[rtl/lpd_in_reg.sv]
// Input register stage of the deframer.
`default_nettype none

module lpd_in_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  lpd_in_if.sink             in_i,
  input  wire logic          take_i,
  output lpd_pkg::item_t     item_o,
  output logic               valid_o
);

  logic           valid_q, valid_d;
  lpd_pkg::item_t item_q;
  logic           load;

  assign in_i.ready = !valid_q || take_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.in_byte       <= in_i.in_byte;
      item_q.end_of_stream <= in_i.end_of_stream;
    end
  end

  assign item_o  = item_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

[rtl/lpd_core.sv]
// Frame state, header assembly, length checks and the result register.
`default_nettype none

module lpd_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [lpd_pkg::MaxBits-1:0] cfg_wdata_i,
  input  wire logic                       valid_i,
  input  wire lpd_pkg::item_t             item_i,
  output logic                            take_o,
  lpd_out_if.source                       out_o
);

  localparam int unsigned LB = lpd_pkg::LengthBits;

  // frame state
  logic                          in_payload_q, in_payload_d;
  logic [1:0]                    hdr_cnt_q, hdr_cnt_d;
  logic [23:0]                   hdr_q, hdr_d;
  logic [LB-1:0]                 left_q, left_d;
  logic [lpd_pkg::MaxBits-1:0]   max_q;

  // result register
  logic                          out_valid_q, out_valid_d;
  lpd_pkg::kind_e                kind_q, kind_d;
  logic [7:0]                    byte_q, byte_d;
  logic                          last_q, last_d;
  lpd_pkg::err_e                 err_q, err_d;
  logic                          emit;

  logic [31:0]                   header_full;
  logic [LB-1:0]                 len;
  logic                          over_max;

  assign take_o      = valid_i && (!out_valid_q || out_o.ready);
  assign header_full = {item_i.in_byte, hdr_q};
  assign len         = header_full[LB-1:0];
  assign over_max    = lpd_pkg::MaxBits'(len) > max_q;

  always_comb begin
    in_payload_d = in_payload_q;
    hdr_cnt_d    = hdr_cnt_q;
    hdr_d        = hdr_q;
    left_d       = left_q;
    emit         = 1'b0;
    kind_d       = lpd_pkg::KIND_PAYLOAD;
    byte_d       = 8'd0;
    last_d       = 1'b0;
    err_d        = lpd_pkg::ERR_NONE;

    if (take_o) begin
      if (item_i.end_of_stream) begin
        emit = 1'b1;
        kind_d = lpd_pkg::KIND_END;
        if (in_payload_q) begin
          kind_d = lpd_pkg::KIND_ERROR;
          err_d  = lpd_pkg::ERR_TRUNC_PAYLOAD;
        end else if (hdr_cnt_q != 2'd0) begin
          kind_d = lpd_pkg::KIND_ERROR;
          err_d  = lpd_pkg::ERR_TRUNC_HEADER;
        end
        in_payload_d = 1'b0;
        hdr_cnt_d    = 2'd0;
        hdr_d        = '0;
        left_d       = '0;
      end else if (in_payload_q) begin
        emit   = 1'b1;
        byte_d = item_i.in_byte;
        // an empty count also closes the frame
        last_d = left_q <= LB'(1);
        if (last_d) begin
          in_payload_d = 1'b0;
          left_d       = '0;
        end else begin
          left_d = left_q - LB'(1);
        end
      end else begin
        case (hdr_cnt_q)
          2'd0: hdr_d[7:0]   = item_i.in_byte;
          2'd1: hdr_d[15:8]  = item_i.in_byte;
          2'd2: hdr_d[23:16] = item_i.in_byte;
          default: begin
            // fourth header byte completes the length
            hdr_d = '0;
            if (len == '0) begin
              emit   = 1'b1;
              kind_d = lpd_pkg::KIND_ERROR;
              err_d  = lpd_pkg::ERR_ZERO_LENGTH;
            end else if (over_max) begin
              emit   = 1'b1;
              kind_d = lpd_pkg::KIND_ERROR;
              err_d  = lpd_pkg::ERR_OVER_MAX;
            end else begin
              in_payload_d = 1'b1;
              left_d       = len;
            end
          end
        endcase
        hdr_cnt_d = hdr_cnt_q + 2'd1;
      end
    end

    out_valid_d = out_valid_q && !out_o.ready;
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      hdr_cnt_q    <= 2'd0;
      hdr_q        <= '0;
      left_q       <= '0;
      max_q        <= '1;
      out_valid_q  <= 1'b0;
    end else begin
      in_payload_q <= in_payload_d;
      hdr_cnt_q    <= hdr_cnt_d;
      hdr_q        <= hdr_d;
      left_q       <= left_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= kind_d;
      byte_q <= byte_d;
      last_q <= last_d;
      err_q  <= err_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.result_kind   = kind_q;
  assign out_o.payload_byte  = byte_q;
  assign out_o.last_in_frame = last_q;
  assign out_o.error_code    = err_q;

endmodule

`default_nettype wire

[rtl/lpd_checker.sv]
// Port-level checks of the deframer, bound to the top level.
`default_nettype none

module lpd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [1:0] result_kind_i,
  input wire logic [7:0] payload_byte_i,
  input wire logic       last_in_frame_i,
  input wire logic [2:0] error_code_i
);

  // a waiting result stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a waiting result keeps its fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(result_kind_i) && $stable(payload_byte_i) &&
      $stable(last_in_frame_i) && $stable(error_code_i))
    else $error("stalled result changed");

  // an error carries a code, other results do not
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      ((result_kind_i == lpd_pkg::KIND_ERROR) == (error_code_i != lpd_pkg::ERR_NONE)))
    else $error("error code does not match result kind");

  // only payload items carry a byte or a last mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && result_kind_i != lpd_pkg::KIND_PAYLOAD |->
      payload_byte_i == 8'd0 && !last_in_frame_i)
    else $error("non-payload result carries payload fields");

endmodule

bind length_prefixed_deframer lpd_checker u_lpd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .result_kind_i   (out_o.result_kind),
  .payload_byte_i  (out_o.payload_byte),
  .last_in_frame_i (out_o.last_in_frame),
  .error_code_i    (out_o.error_code)
);

`default_nettype wire
